### rtl/core/ddq_pkg.sv
// shared constants, command codes and control types for the ring deque
`timescale 1ns / 1ps
`default_nettype none
package ddq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int FUNC_W       = 3;
    localparam int DATA_W       = 32;
    localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

    // command codes, codes above peek behave as peek
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK       = 3'd4;

    typedef struct packed {
        logic exec;   // run the accepted request against the state
        logic load;   // take refill data for the cached end
    } t_ddq_cmd;

    typedef struct packed {
        logic needs_load;  // request needs a store read to refill an end
    } t_ddq_status;

endpackage
`default_nettype wire

### rtl/core/ddq_if.sv
// request and result channel interfaces for the ring deque
`timescale 1ns / 1ps
`default_nettype none
interface ddq_in_if;
    import ddq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [FUNC_W-1:0] func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface ddq_out_if #(
    parameter int CNT_W = ddq_pkg::CNT_W_DEF
);
    import ddq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic                     pop_on_empty;
    logic                     push_on_full;
    logic        [CNT_W-1:0]  count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;

    modport source (
        output valid, output popped_value, output pop_on_empty, output push_on_full,
        output count, output is_empty, output front_value, output back_value,
        input  ready
    );
    modport sink (
        input  valid, input popped_value, input pop_on_empty, input push_on_full,
        input  count, input is_empty, input front_value, input back_value,
        output ready
    );
endinterface
`default_nettype wire

### rtl/core/double_ended_queue_ring.sv
// top level of the bounded ring deque of signed 32-bit values
// usage:
//   i_cmd carries one request (func, value) under a valid/ready handshake;
//   func selects push front, push back, pop front, pop back or peek, and
//   codes above peek act as peek. o_rsp returns exactly one result per
//   request: popped value, pop-on-empty and push-on-full flags, element
//   count, empty flag, and the front and back elements after the request.
// sequence:
//   one request at a time. a push or peek is accepted in the idle state, then
//   the result is shown and its handshake completed, after which i_cmd.ready
//   rises again; a pop that leaves an element behind first passes through a
//   refill state, needed by the registered read port of the element store that
//   refills the cached front or back value.
// stalls:
//   the result register holds while o_rsp.ready is low, and i_cmd.ready
//   stays low until the result has been taken.
// reset:
//   synchronous active-low reset empties the queue (head and count go to
//   zero); the store contents are not cleared and no clearing pass runs,
//   since only data read from slots holding queued elements is ever used.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_ring #(
    parameter int CAPACITY = ddq_pkg::CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ddq_in_if.sink     i_cmd,
    ddq_out_if.source  o_rsp
);
    import ddq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_ddq_cmd    w_cmd;
    t_ddq_status w_status;

    // sequencer: handshakes on both channels, sequencing of exec and refill
    ddq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: head, count, cached ends, result registers and the store
    ddq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_func         (i_cmd.func),
        .i_value        (i_cmd.value),
        .o_popped_value (o_rsp.popped_value),
        .o_pop_on_empty (o_rsp.pop_on_empty),
        .o_push_on_full (o_rsp.push_on_full),
        .o_count        (o_rsp.count[CNT_W-1:0]),
        .o_is_empty     (o_rsp.is_empty),
        .o_front_value  (o_rsp.front_value),
        .o_back_value   (o_rsp.back_value)
    );

endmodule
`default_nettype wire

### rtl/core/ddq_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ddq_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/ddq_ctrl.sv
// request sequencer for the ring deque
`timescale 1ns / 1ps
`default_nettype none
module ddq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire ddq_pkg::t_ddq_status i_status,
    output ddq_pkg::t_ddq_cmd         o_cmd
);
    import ddq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.needs_load ? S_LOAD : S_RESP;
                end
            end
            S_LOAD: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.exec  = w_accept;
    assign o_cmd.load  = (r_state == S_LOAD);

endmodule
`default_nettype wire

### rtl/core/ddq_datapath.sv
// ring pointers, cached ends, result registers and element store
`timescale 1ns / 1ps
`default_nettype none
module ddq_datapath #(
    parameter  int CAPACITY = ddq_pkg::CAPACITY_DEF,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ddq_pkg::t_ddq_cmd               i_cmd,
    output ddq_pkg::t_ddq_status                 o_status,
    input  wire logic        [ddq_pkg::FUNC_W-1:0] i_func,
    input  wire logic signed [ddq_pkg::DATA_W-1:0] i_value,
    output logic signed      [ddq_pkg::DATA_W-1:0] o_popped_value,
    output logic                                 o_pop_on_empty,
    output logic                                 o_push_on_full,
    output logic             [CNT_W-1:0]         o_count,
    output logic                                 o_is_empty,
    output logic signed      [ddq_pkg::DATA_W-1:0] o_front_value,
    output logic signed      [ddq_pkg::DATA_W-1:0] o_back_value
);
    import ddq_pkg::*;

    localparam int SUM_W = IDX_W + 1;

    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_back, n_back;
    logic [DATA_W-1:0] r_popped, n_popped;
    logic              r_poe, n_poe;
    logic              r_pof, n_pof;
    logic              r_load_front, n_load_front;

    logic              w_full, w_empty;
    logic [IDX_W-1:0]  w_head_dec, w_head_inc;
    logic [IDX_W-1:0]  w_tail_slot, w_prev_last_slot;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [DATA_W-1:0] w_rdata;

    // head plus offset, offset below twice the capacity
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        if (s >= SUM_W'(CAPACITY)) begin
            t = s - SUM_W'(CAPACITY);
        end else begin
            t = s;
        end
        return t[IDX_W-1:0];
    endfunction

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_head_dec = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - IDX_W'(1);
    assign w_head_inc = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + IDX_W'(1);
    assign w_tail_slot      = wrap_slot({1'b0, r_head} + SUM_W'(r_count));
    assign w_prev_last_slot = wrap_slot({1'b0, r_head} + SUM_W'(r_count) - SUM_W'(2));

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_popped     = r_popped;
        n_poe        = r_poe;
        n_pof        = r_pof;
        n_load_front = r_load_front;
        w_we         = 1'b0;
        w_waddr      = w_tail_slot;
        w_raddr      = w_head_inc;
        o_status.needs_load = 1'b0;

        unique case (i_func)
            FN_POP_FRONT: begin
                w_raddr = w_head_inc;
                o_status.needs_load = (r_count > CNT_W'(1));
            end
            FN_POP_BACK: begin
                w_raddr = w_prev_last_slot;
                o_status.needs_load = (r_count > CNT_W'(1));
            end
            default: begin
                o_status.needs_load = 1'b0;
            end
        endcase

        if (i_cmd.exec) begin
            n_popped = '0;
            n_poe    = 1'b0;
            n_pof    = 1'b0;
            unique case (i_func)
                FN_PUSH_FRONT: begin
                    if (w_full) begin
                        n_pof = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_head_dec;
                        n_head  = w_head_dec;
                        n_count = r_count + CNT_W'(1);
                        n_front = i_value;
                        if (w_empty) begin
                            n_back = i_value;
                        end
                    end
                end
                FN_PUSH_BACK: begin
                    if (w_full) begin
                        n_pof = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_tail_slot;
                        n_count = r_count + CNT_W'(1);
                        n_back  = i_value;
                        if (w_empty) begin
                            n_front = i_value;
                        end
                    end
                end
                FN_POP_FRONT: begin
                    if (w_empty) begin
                        n_poe = 1'b1;
                    end else begin
                        n_popped     = r_front;
                        n_head       = w_head_inc;
                        n_count      = r_count - CNT_W'(1);
                        n_load_front = 1'b1;
                    end
                end
                FN_POP_BACK: begin
                    if (w_empty) begin
                        n_poe = 1'b1;
                    end else begin
                        n_popped     = r_back;
                        n_count      = r_count - CNT_W'(1);
                        n_load_front = 1'b0;
                    end
                end
                default: begin
                    n_popped = '0;
                end
            endcase
        end

        // refill the end that a pop uncovered
        if (i_cmd.load) begin
            if (r_load_front) begin
                n_front = w_rdata;
            end else begin
                n_back = w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_back       <= n_back;
        r_popped     <= n_popped;
        r_poe        <= n_poe;
        r_pof        <= n_pof;
        r_load_front <= n_load_front;
    end

    ddq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_popped_value = r_popped;
    assign o_pop_on_empty = r_poe;
    assign o_push_on_full = r_pof;
    assign o_count        = r_count;
    assign o_is_empty     = w_empty;
    assign o_front_value  = w_empty ? '0 : r_front;
    assign o_back_value   = w_empty ? '0 : r_back;

endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the ring deque: predicts each result and compares it field by field
`timescale 1ns / 1ps
module tb_top;
    import ddq_pkg::*;

    // codes above peek are not named in the package, they must act as peek
    localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    localparam int CAP         = CAPACITY_DEF;
    localparam int CNT_W       = CNT_W_DEF;
    localparam int DRAIN_WAIT  = 20;       // margin after the last result, leave plenty
    localparam int HOLD_CYCLES = 300;      // long result hold-off for the back-pressure test
    localparam int CYCLE_LIMIT = 400000;

    // one result as the block reports it
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     pop_on_empty;
        logic                     push_on_full;
        logic        [CNT_W-1:0]  count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    ddq_in_if  cmd_if ();
    ddq_out_if rsp_if ();

    double_ended_queue_ring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // own copy of the deque: ring store, head slot and element count
    logic signed [DATA_W-1:0] shadow_ring [CAP];
    logic [9:0]               shadow_head;
    logic [CNT_W-1:0]         shadow_count;

    // results still owed by the block, oldest first
    t_deque_result pending_results[$];

    int  mismatch_count      = 0;
    bit  gaps_on             = 1'b1;   // both sides idle at random while set
    int  hold_request_cycles = 0;      // asks the result side for a long hold-off

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // applies one request to the shadow deque and returns what the block should report
    function automatic t_deque_result deque_apply(input logic [FUNC_W-1:0] fn,
                                                  input logic signed [DATA_W-1:0] v);
        t_deque_result r;
        logic [9:0]    back_slot;
        r = '0;
        case (fn)
            FN_PUSH_FRONT: begin
                if (shadow_count == CAP) begin
                    r.push_on_full = 1'b1;
                end else begin
                    // head slot steps back, wrapping from 0 to the top of the ring
                    shadow_head              = shadow_head - 10'd1;
                    shadow_ring[shadow_head] = v;
                    shadow_count             = shadow_count + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (shadow_count == CAP) begin
                    r.push_on_full = 1'b1;
                end else begin
                    back_slot              = shadow_head + shadow_count[9:0];
                    shadow_ring[back_slot] = v;
                    shadow_count           = shadow_count + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.pop_on_empty = 1'b1;
                end else begin
                    r.popped_value = shadow_ring[shadow_head];
                    shadow_head    = shadow_head + 10'd1;
                    shadow_count   = shadow_count - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.pop_on_empty = 1'b1;
                end else begin
                    back_slot      = shadow_head + shadow_count[9:0] - 10'd1;
                    r.popped_value = shadow_ring[back_slot];
                    shadow_count   = shadow_count - 1'b1;
                end
            end
            default: ;  // peek and the unused codes leave the deque alone
        endcase
        r.count    = shadow_count;
        r.is_empty = (shadow_count == 0);
        if (shadow_count != 0) begin
            back_slot     = shadow_head + shadow_count[9:0] - 10'd1;
            r.front_value = shadow_ring[shadow_head];
            r.back_value  = shadow_ring[back_slot];
        end
        return r;
    endfunction

    // sends one request, then records what it should produce once accepted;
    // valid stays high on return so a back-to-back request needs no extra edge
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= fn;
        cmd_if.value <= v;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results = {pending_results, deque_apply(fn, v)};
    endtask

    // sender drops valid and waits for every owed result
    task automatic hold_sender_until_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // element values lean on the sign and width extremes
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // picks a command with the given push and pop shares in percent, the rest peeks
    function automatic logic [FUNC_W-1:0] draw_func(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
        // peek or one of the codes above it
        return FN_PEEK + 3'($urandom_range(0, 3));
    endfunction

    task automatic run_random(input int n, input int push_pct, input int pop_pct);
        for (int i = 0; i < n; i++) begin
            // now and then switch idling off for a stretch
            if (i % 48 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_request(draw_func(push_pct, pop_pct), draw_value());
        end
        gaps_on = 1'b1;
    endtask

    // pops and peeks on an empty deque, codes above peek included
    task automatic test_empty_queue();
        send_request(FN_PEEK,      32'sd5);
        send_request(FN_POP_FRONT, 32'sd9);
        send_request(FN_POP_BACK,  -32'sd9);
        send_request(FN_RSVD_5,    32'sh7fff_ffff);
        send_request(FN_RSVD_6,    32'sh8000_0000);
        send_request(FN_RSVD_7,    -32'sd1);
    endtask

    // every command at both ends with extreme values, pops that leave one
    // element and pops that empty the deque, then a pause until all results are back
    task automatic test_basic_ops();
        send_request(FN_PUSH_FRONT, 32'sh7fff_ffff);  // head wraps below slot 0
        send_request(FN_PUSH_BACK,  32'sh8000_0000);
        send_request(FN_PEEK,       '0);
        send_request(FN_PUSH_FRONT, -32'sd1);
        send_request(FN_PUSH_BACK,  '0);
        send_request(FN_POP_BACK,   '0);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_POP_FRONT,  '0);              // one element left
        send_request(FN_POP_BACK,   '0);              // now empty
        send_request(FN_PUSH_BACK,  32'sd1);
        send_request(FN_PUSH_BACK,  32'sd2);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_PUSH_FRONT, 32'sh5555_5555);
        send_request(FN_PUSH_BACK,  32'shaaaa_aaaa);
        send_request(FN_RSVD_6,     32'sh1234_5678);
        send_request(FN_POP_BACK,   '0);
        hold_sender_until_drained();
    endtask

    // the result side holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_request_cycles = HOLD_CYCLES;
        run_random(40, 70, 20);
    endtask

    // fill up to capacity, keep pushing at full, mix pops and pushes near full
    task automatic test_fill_to_full();
        while (shadow_count < CAP)
            run_random(32, 88, 6);
        run_random(48, 60, 25);
    endtask

    // main sequence
    initial begin
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.func  <= FN_PEEK;
        cmd_if.value <= '0;
        shadow_head  = '0;
        shadow_count = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_basic_ops();
        run_random(200, 40, 40);       // low fill, lots of empty pops
        test_backpressure();
        test_fill_to_full();
        run_random(300, 10, 85);       // mostly draining

        hold_sender_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[double_ended_queue_ring] OK");
        else
            $display("[double_ended_queue_ring] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic signed [63:0] want_v,
                                   input logic signed [63:0] got_v);
        mismatch_count++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // result side: random stalls, long hold-off on request, compare every result
    initial begin : result_checker
        t_deque_result want;
        int            stall_left;
        int            hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request outstanding, count %0d",
                             $time, rsp_if.count);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (rsp_if.popped_value !== want.popped_value)
                        report_mismatch("popped_value", want.popped_value, rsp_if.popped_value);
                    if (rsp_if.pop_on_empty !== want.pop_on_empty)
                        report_mismatch("pop_on_empty", want.pop_on_empty, rsp_if.pop_on_empty);
                    if (rsp_if.push_on_full !== want.push_on_full)
                        report_mismatch("push_on_full", want.push_on_full, rsp_if.push_on_full);
                    if (rsp_if.count !== want.count)
                        report_mismatch("count", want.count, rsp_if.count);
                    if (rsp_if.is_empty !== want.is_empty)
                        report_mismatch("is_empty", want.is_empty, rsp_if.is_empty);
                    if (rsp_if.front_value !== want.front_value)
                        report_mismatch("front_value", want.front_value, rsp_if.front_value);
                    if (rsp_if.back_value !== want.back_value)
                        report_mismatch("back_value", want.back_value, rsp_if.back_value);
                end
                stall_left = gaps_on ? $urandom_range(0, 9) : 0;
            end
            // a long hold-off is counted here, not by the sender
            if (hold_request_cycles > 0) begin
                hold_left           = hold_request_cycles;
                hold_request_cycles = 0;
            end
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run limit reached with %0d results outstanding",
                 $time, pending_results.size());
        $display("[double_ended_queue_ring] ERROR");
        $finish;
    end

endmodule
